@@ hdl/lsrg_pkg.sv @@
// lsrg_pkg: constants, payload types and controller/datapath command types
// for the shuffled minimal-standard lehmer generator; no dependencies
`default_nettype none

package lsrg_pkg;

   localparam int unsigned VALUE_W = 31;
   localparam int unsigned MULT_W  = 15;
   localparam int unsigned PROD_W  = VALUE_W + MULT_W;

   localparam logic [MULT_W-1:0]  PM_MULT    = 15'd16807;
   localparam logic [VALUE_W-1:0] PM_MODULUS = 31'h7FFF_FFFF;

   localparam logic FUNC_DRAW   = 1'b0;
   localparam logic FUNC_RESEED = 1'b1;

   typedef struct packed {
      logic               func;
      logic [VALUE_W-1:0] seed_value;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0] random_value;
   } rsp_payload_type;

   typedef struct packed {
      logic seed_load;
      logic seed_one;
      logic seed_fold;
      logic draw_read;
      logic draw_fold;
   } cmd_type;

   typedef struct packed {
      logic seed_last;
   } status_type;

endpackage

`default_nettype wire

@@ hdl/lsrg_req_if.sv @@
// lsrg_req_if: request channel, valid/ready with request payload
// depends on lsrg_pkg
`default_nettype none

interface lsrg_req_if import lsrg_pkg::*;;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/lsrg_rsp_if.sv @@
// lsrg_rsp_if: response channel, valid/ready with response payload
// depends on lsrg_pkg
`default_nettype none

interface lsrg_rsp_if import lsrg_pkg::*;;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/lsrg_dpath.sv @@
// lsrg_dpath: lehmer step (multiply, mersenne fold), step counter, shuffle
// table memory, last output and response data register; depends on lsrg_pkg
`default_nettype none

module lsrg_dpath import lsrg_pkg::*; #(
   parameter int unsigned TABLE_ENTRIES = 32,
   parameter int unsigned WARMUP_STEPS  = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [VALUE_W-1:0] seed_value,
   input  wire cmd_type            cmd,
   output status_type              status,
   output logic      [VALUE_W-1:0] random_value
);

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam int unsigned CNT_W = $clog2(WARMUP_STEPS + TABLE_ENTRIES + 1);
   localparam longint unsigned PICK_DIV =
      64'd1 + (64'(PM_MODULUS) - 64'd1) / 64'(TABLE_ENTRIES);

   logic [PROD_W-1:0]  prod_ff;
   logic [VALUE_W-1:0] state_ff, state_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic [VALUE_W-1:0] rd_ff;
   logic [VALUE_W-1:0] out_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   pick, pick_ff;
   logic [VALUE_W-1:0] seed_norm;
   logic [VALUE_W:0]   fold_sum;
   logic [VALUE_W-1:0] folded;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [VALUE_W-1:0] table_mem [TABLE_ENTRIES];

   // product of a 31-bit value and a 15-bit constant, folded mod 2^31-1
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(state_ff) * PROD_W'(PM_MULT);
   end

   always_comb begin
      fold_sum = {1'b0, prod_ff[VALUE_W-1:0]} + (VALUE_W+1)'(prod_ff[PROD_W-1:VALUE_W]);
      if (fold_sum >= {1'b0, PM_MODULUS}) begin
         folded = VALUE_W'(fold_sum - {1'b0, PM_MODULUS});
      end else begin
         folded = fold_sum[VALUE_W-1:0];
      end
   end

   always_comb begin
      if (cmd.seed_one || seed_value == '0 || seed_value == PM_MODULUS) begin
         seed_norm = VALUE_W'(1);
      end else begin
         seed_norm = seed_value;
      end
   end

   // thermometer compare against multiples of the pick divisor
   always_comb begin
      pick = '0;
      for (int k = 1; k < int'(TABLE_ENTRIES); k++) begin
         if ({1'b0, last_ff} >= 32'(longint'(k) * PICK_DIV)) begin
            pick = IDX_W'(k);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      if (cmd.seed_load) begin
         state_in = seed_norm;
         cnt_in   = CNT_W'(WARMUP_STEPS + TABLE_ENTRIES);
      end
      if (cmd.seed_fold) begin
         state_in = folded;
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            last_in = folded;
         end
      end
      if (cmd.draw_fold) begin
         state_in = folded;
         last_in  = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= VALUE_W'(1);
         last_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.draw_read) begin
         pick_ff <= pick;
      end
      if (cmd.draw_fold) begin
         out_ff <= rd_ff;
      end
   end

   // fill runs from the highest entry down to entry 0
   always_comb begin
      mem_we    = cmd.draw_fold || (cmd.seed_fold && cnt_ff <= CNT_W'(TABLE_ENTRIES));
      mem_waddr = cmd.draw_fold ? pick_ff : IDX_W'(cnt_ff - CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= folded;
      end
      rd_ff <= table_mem[pick];
   end

   assign status.seed_last = (cnt_ff == CNT_W'(1));
   assign random_value     = out_ff;

endmodule

`default_nettype wire

@@ hdl/lsrg_ctrl.sv @@
// lsrg_ctrl: sequencer for seeding and draws, seeded flag, response valid
// depends on lsrg_pkg
`default_nettype none

module lsrg_ctrl import lsrg_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_func,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SEED_MUL  = 3'd1;
   localparam logic [2:0] ST_SEED_FOLD = 3'd2;
   localparam logic [2:0] ST_DRAW_MUL  = 3'd3;
   localparam logic [2:0] ST_DRAW_FOLD = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       seeded_ff, seeded_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
   assign out_free  = !valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      seeded_in = seeded_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_RESEED || !seeded_ff) begin
                  cmd.seed_load = 1'b1;
                  cmd.seed_one  = (req_func == FUNC_DRAW);
                  seeded_in     = 1'b1;
                  state_in      = ST_SEED_MUL;
               end else begin
                  state_in = ST_DRAW_MUL;
               end
            end
         end
         ST_SEED_MUL: begin
            state_in = ST_SEED_FOLD;
         end
         ST_SEED_FOLD: begin
            cmd.seed_fold = 1'b1;
            state_in      = status.seed_last ? ST_DRAW_MUL : ST_SEED_MUL;
         end
         ST_DRAW_MUL: begin
            cmd.draw_read = 1'b1;
            if (out_free) begin
               state_in = ST_DRAW_FOLD;
            end
         end
         ST_DRAW_FOLD: begin
            cmd.draw_fold = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.draw_fold) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seeded_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seeded_ff <= seeded_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/lehmer_shuffle_random_generator.sv @@
// channel  dir  payload                       handshake
// req      in   func, seed_value              req.valid / req.ready
// rsp      out  random_value                  rsp.valid / rsp.ready
//
// after acceptance a draw runs DRAW_MUL and then DRAW_FOLD, which registers
// the response; no new item is taken until the controller is back in IDLE;
// a reseed, or the first draw after reset, runs WARMUP_STEPS +
// TABLE_ENTRIES lehmer steps, each a multiply then a fold, before its draw
// synchronous active-high reset; the shuffle table needs no clearing pass
// a new item is taken while the previous response waits; a stalled response
// holds the next draw before its table update
//
// top level: lsrg_ctrl, lsrg_dpath, lsrg_req_if, lsrg_rsp_if, lsrg_pkg
`default_nettype none

module lehmer_shuffle_random_generator import lsrg_pkg::*; #(
   parameter int unsigned TABLE_ENTRIES = 32,
   parameter int unsigned WARMUP_STEPS  = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lsrg_req_if.sink    req,
   lsrg_rsp_if.source  rsp
);

   cmd_type    cmd;
   status_type status;

   lsrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_func  (req.payload.func),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lsrg_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .WARMUP_STEPS  (WARMUP_STEPS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .seed_value   (req.payload.seed_value),
      .cmd          (cmd),
      .status       (status),
      .random_value (rsp.payload.random_value)
   );

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while an item is in progress");

   a_commit_into_empty_output: assert property (@(posedge clock) disable iff (reset)
      cmd.draw_fold |-> !rsp.valid)
      else $error("draw committed while previous response still held");

   a_response_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(cmd.draw_fold))
      else $error("response appeared without a draw commit");

   a_no_seed_during_draw: assert property (@(posedge clock) disable iff (reset)
      cmd.draw_read |-> !cmd.seed_fold && !cmd.seed_load)
      else $error("seeding command issued during a draw");

endmodule

`default_nettype wire

@@ test/lsrg_scoreboard.sv @@
// lsrg_scoreboard: watches the request and response channels, predicts each
// shuffled lehmer value and compares it with the block's response
// depends on lsrg_pkg
`default_nettype none

module lsrg_scoreboard import lsrg_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire rsp_payload_type rsp_payload,
   output int unsigned          error_count,
   output int unsigned          pending_count,
   output int unsigned          checked_count,
   output int unsigned          reseed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned     SLOTS    = 32;
   localparam int unsigned     SLOT_IDX_W = $clog2(SLOTS);
   localparam int unsigned     WARMUP   = 8;
   localparam longint unsigned MODULUS  = 64'd2147483647;
   localparam longint unsigned MULTIPLIER = 64'd16807;
   localparam int unsigned     SLOT_DIV = 1 + (32'd2147483647 - 1) / SLOTS;

   logic [VALUE_W-1:0] lehmer_value;
   logic [VALUE_W-1:0] shuffle_slots [SLOTS];
   logic [VALUE_W-1:0] prev_output;
   logic               is_seeded;
   logic [VALUE_W-1:0] expected_values [$];

   function automatic logic [VALUE_W-1:0] park_miller_step(input logic [VALUE_W-1:0] x);
      longint unsigned product;
      product = MULTIPLIER * {33'd0, x};
      return VALUE_W'(product % MODULUS);
   endfunction

   function automatic void load_generator(input logic [VALUE_W-1:0] seed);
      logic [VALUE_W-1:0] x;
      x = seed;
      if (x == '0 || x == PM_MODULUS) begin
         x = VALUE_W'(1);
      end
      repeat (WARMUP) x = park_miller_step(x);
      for (int n = SLOTS - 1; n >= 0; n--) begin
         x = park_miller_step(x);
         shuffle_slots[n] = x;
      end
      lehmer_value = x;
      prev_output  = shuffle_slots[0];
      is_seeded    = 1'b1;
   endfunction

   function automatic logic [VALUE_W-1:0] next_shuffled(input req_payload_type item);
      logic [SLOT_IDX_W-1:0] pick;
      logic [VALUE_W-1:0]    picked;
      if (item.func == FUNC_RESEED) begin
         load_generator(item.seed_value);
         reseed_count++;
      end else if (!is_seeded) begin
         load_generator(VALUE_W'(1));
      end
      lehmer_value = park_miller_step(lehmer_value);
      pick = SLOT_IDX_W'((32'(prev_output) / SLOT_DIV) % SLOTS);
      picked = shuffle_slots[pick];
      shuffle_slots[pick] = lehmer_value;
      prev_output = picked;
      return picked;
   endfunction

   function automatic void note_error(input string what, input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t error: %s, random_value expected %0d got %0d", $realtime, what, want, got);
      end
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
      reseed_count  = 0;
   end

   always @(posedge clock) begin
      logic [VALUE_W-1:0] want;
      if (reset) begin
         lehmer_value = VALUE_W'(1);
         prev_output  = '0;
         is_seeded    = 1'b0;
         expected_values.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               note_error("response with no item outstanding", '0, rsp_payload.random_value);
            end else begin
               want = expected_values.pop_front();
               checked_count++;
               if (rsp_payload.random_value !== want) begin
                  note_error("value mismatch", want, rsp_payload.random_value);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_values.push_back(next_shuffled(req_payload));
         end
      end
      pending_count = expected_values.size();
   end

   final begin
      if (expected_values.size() != 0) begin
         $display("error: %0d values never returned", expected_values.size());
      end
   end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// tb_top: clock, reset and stimulus for the shuffled lehmer generator, with
// random idling on both channels; checking is done in lsrg_scoreboard
// depends on lsrg_pkg, lsrg_req_if, lsrg_rsp_if, lsrg_scoreboard and the block
`default_nettype none

module tb_top import lsrg_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 800;

   logic        clock;
   logic        reset;
   logic        steady;
   int unsigned error_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned reseed_count;
   int unsigned sent_count;

   lsrg_req_if req_ch ();
   lsrg_rsp_if rsp_ch ();

   lehmer_shuffle_random_generator i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   lsrg_scoreboard i_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_payload   (req_ch.payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_payload   (rsp_ch.payload),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .reseed_count  (reseed_count)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 34);
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d values outstanding", pending_count);
      $display("FAIL");
      $finish;
   end

   // one item per call, starting and ending at a falling edge
   task automatic send_item(input logic func, input logic [VALUE_W-1:0] seed);
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid              <= 1'b1;
      req_ch.payload.func       <= func;
      req_ch.payload.seed_value <= seed;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_seed();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return VALUE_W'(1);
         2: return PM_MODULUS;
         3: return PM_MODULUS - VALUE_W'(1);
         4: return VALUE_W'($urandom_range(0, 255));
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   initial begin
      sent_count     = 0;
      steady         = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // draws before any seeding
      send_item(FUNC_DRAW, 31'h7FFF_FFFF);
      send_item(FUNC_DRAW, '0);
      send_item(FUNC_DRAW, 31'h2AAA_AAAA);
      // zero seed, seed equal to the modulus, and the range limits
      send_item(FUNC_RESEED, '0);
      send_item(FUNC_DRAW, 31'h5555_5555);
      send_item(FUNC_RESEED, PM_MODULUS);
      send_item(FUNC_DRAW, '0);
      send_item(FUNC_RESEED, 31'd1);
      send_item(FUNC_DRAW, '0);
      send_item(FUNC_RESEED, PM_MODULUS - VALUE_W'(1));
      send_item(FUNC_DRAW, '0);
      send_item(FUNC_DRAW, '0);
      send_item(FUNC_RESEED, 31'h5555_5555);
      send_item(FUNC_RESEED, 31'h2AAA_AAAA);
      repeat (6) send_item(FUNC_DRAW, VALUE_W'($urandom()));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 350 && i < 500);
         if ($urandom_range(0, 24) == 0) begin
            send_item(FUNC_RESEED, pick_seed());
         end else begin
            send_item(FUNC_DRAW, VALUE_W'($urandom()));
         end
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      wait (pending_count == 0);
      repeat (10) @(posedge clock);
      $display("%0d items sent, %0d of them reseeds, %0d values checked",
               sent_count, reseed_count, checked_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
